/* hdl/cursor_sequence_buffer_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cursor sequence buffer
// Shared property forms used by the checker; each one reports through $error.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/csb_pkg.sv */
// ----------------------------------------------------------------------------
// csb_pkg
// Command codes, status codes and field widths of the cursor sequence buffer.
// ----------------------------------------------------------------------------
package csb_pkg;

	// Field widths fixed by the interface.
	localparam int CMD_W     = 3;
	localparam int ELEM_W    = 8;
	localparam int SEQ_LEN_W = 9;
	localparam int STATUS_W  = 2;

	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [ELEM_W-1:0]    elem_t;
	typedef logic [SEQ_LEN_W-1:0] seq_len_t;
	typedef logic [STATUS_W-1:0]  status_t;

	// Command codes.
	localparam cmd_t CMD_REWIND = 3'd0;
	localparam cmd_t CMD_STEP   = 3'd1;
	localparam cmd_t CMD_INS_L  = 3'd2;
	localparam cmd_t CMD_INS_R  = 3'd3;
	localparam cmd_t CMD_ERASE  = 3'd4;
	localparam cmd_t CMD_READ   = 3'd5;

	// Status codes.
	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_FULL    = 2'd1;
	localparam status_t STAT_AT_STOP = 2'd2;

endpackage

/* hdl/csb_ram.sv */
// ----------------------------------------------------------------------------
// csb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/cursor_sequence_buffer_core.sv */
// Sequence: rewind, step, read and refused commands pass from the input transfer through
//   S_RDC and S_CAP to the output register; erase and insert first shift the bytes behind
//   the cursor in S_SHIFT, and insert then writes the new byte in S_WRV. The next input is
//   taken only after the result is registered; the shift moves one byte per cycle through the RAM.
// Reset: arst_n clears the cursor, the length and the handshake state; the byte store
//   is not cleared, as only entries below the length are ever read.
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core
// Ordered byte sequence with a cursor, held in one RAM and edited by shifting.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core #(
	parameter int CAPACITY = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csb_pkg::cmd_t        command,
	input  csb_pkg::elem_t       elem_in,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output csb_pkg::elem_t       elem_out,
	output logic                 at_start,
	output logic                 at_stop,
	output csb_pkg::seq_len_t    seq_length,
	output csb_pkg::status_t     status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_WRV   = 3'd2;
	localparam logic [2:0] S_RDC   = 3'd3;
	localparam logic [2:0] S_CAP   = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       cursor_q;
	logic [CW-1:0]       count_q;
	csb_pkg::status_t    stat_q;
	logic                dir_up_q;
	logic                do_wrv_q;
	logic [CW-1:0]       shift_cnt_q;
	logic [CW-1:0]       rd_idx_q;
	logic [AW-1:0]       wr_pos_q;
	csb_pkg::elem_t      value_q;
	logic                valid_s1;
	logic [AW-1:0]       waddr_s1;

	logic                out_valid_q;
	csb_pkg::elem_t      elem_out_q;
	logic                at_start_q;
	logic                at_stop_q;
	csb_pkg::seq_len_t   seq_length_q;
	csb_pkg::status_t    status_q;

	logic                in_xfer;
	logic                out_free;
	logic                stop_c;
	logic                full_c;
	logic                empty_c;

	csb_pkg::status_t    dec_status;
	logic [CW-1:0]       dec_cursor;
	logic [CW-1:0]       dec_count;
	logic                dec_ins;
	logic                dec_del;
	logic [CW-1:0]       dec_pos;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	csb_pkg::elem_t      ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	csb_pkg::elem_t      ram_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign stop_c  = (cursor_q >= count_q);
	assign full_c  = (count_q >= CAP_C);
	assign empty_c = (count_q == '0);

	// Command decode against the current cursor and length.
	always_comb begin
		dec_status = csb_pkg::STAT_OK;
		dec_cursor = cursor_q;
		dec_count  = count_q;
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_pos    = cursor_q;
		unique case (command)
			csb_pkg::CMD_REWIND: begin
				dec_cursor = '0;
			end
			csb_pkg::CMD_STEP: begin
				if (stop_c) begin
					dec_status = csb_pkg::STAT_AT_STOP;
				end else begin
					dec_cursor = cursor_q + 1'b1;
				end
			end
			csb_pkg::CMD_INS_L: begin
				if (full_c) begin
					dec_status = csb_pkg::STAT_FULL;
				end else begin
					dec_ins   = 1'b1;
					dec_count = count_q + 1'b1;
				end
			end
			csb_pkg::CMD_INS_R: begin
				priority if (full_c) begin
					dec_status = csb_pkg::STAT_FULL;
				end else if (empty_c) begin
					dec_cursor = '0;
					dec_pos    = '0;
					dec_ins    = 1'b1;
					dec_count  = count_q + 1'b1;
				end else if (stop_c) begin
					dec_status = csb_pkg::STAT_AT_STOP;
				end else begin
					dec_cursor = cursor_q + 1'b1;
					dec_pos    = cursor_q + 1'b1;
					dec_ins    = 1'b1;
					dec_count  = count_q + 1'b1;
				end
			end
			csb_pkg::CMD_ERASE: begin
				if (stop_c) begin
					dec_status = csb_pkg::STAT_AT_STOP;
				end else begin
					dec_del   = 1'b1;
					dec_count = count_q - 1'b1;
				end
			end
			csb_pkg::CMD_READ: begin
				if (stop_c) begin
					dec_status = csb_pkg::STAT_AT_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	// RAM port steering: shift writes from the pipeline stage, then the new byte.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cursor_q[AW-1:0];
		if (state_q == S_SHIFT) begin
			ram_re    = (shift_cnt_q != '0);
			ram_raddr = rd_idx_q[AW-1:0];
		end else if (state_q == S_RDC) begin
			ram_re = 1'b1;
		end
		ram_we    = valid_s1 || (state_q == S_WRV);
		ram_waddr = valid_s1 ? waddr_s1 : wr_pos_q;
		ram_wdata = valid_s1 ? ram_rdata : value_q;
	end

	csb_ram #(
		.WIDTH (csb_pkg::ELEM_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shift pipeline: a byte read in one cycle is written one place over in the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SHIFT) && (shift_cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= dir_up_q ? AW'(rd_idx_q + 1'b1) : AW'(rd_idx_q - 1'b1);
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cursor_q <= dec_cursor;
						count_q  <= dec_count;
						state_q  <= (dec_ins || dec_del) ? S_SHIFT : S_RDC;
					end
				end
				S_SHIFT: begin
					if (shift_cnt_q == '0) begin
						state_q <= do_wrv_q ? S_WRV : S_RDC;
					end
				end
				S_WRV: begin
					state_q <= S_RDC;
				end
				S_RDC: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-command working registers; set up on the input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			stat_q   <= dec_status;
			dir_up_q <= dec_ins;
			do_wrv_q <= dec_ins;
			wr_pos_q <= dec_pos[AW-1:0];
			value_q  <= elem_in;
			if (dec_ins) begin
				rd_idx_q    <= count_q - 1'b1;
				shift_cnt_q <= count_q - dec_pos;
			end else if (dec_del) begin
				rd_idx_q    <= dec_pos + 1'b1;
				shift_cnt_q <= count_q - dec_pos - 1'b1;
			end else begin
				rd_idx_q    <= dec_pos;
				shift_cnt_q <= '0;
			end
		end else if ((state_q == S_SHIFT) && (shift_cnt_q != '0)) begin
			rd_idx_q    <= dir_up_q ? rd_idx_q - 1'b1 : rd_idx_q + 1'b1;
			shift_cnt_q <= shift_cnt_q - 1'b1;
		end
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_CAP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CAP) && out_free) begin
			elem_out_q   <= stop_c ? '0 : ram_rdata;
			at_start_q   <= (cursor_q == '0);
			at_stop_q    <= stop_c;
			seq_length_q <= csb_pkg::SEQ_LEN_W'(count_q);
			status_q     <= stat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign elem_out   = elem_out_q;
	assign at_start   = at_start_q;
	assign at_stop    = at_stop_q;
	assign seq_length = seq_length_q;
	assign status     = status_q;

endmodule

/* hdl/csb_checker.sv */
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks on the results of the cursor sequence buffer.
// ----------------------------------------------------------------------------
`include "cursor_sequence_buffer_core_assert.svh"

module csb_checker #(
	parameter int CAPACITY = 256
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input csb_pkg::elem_t    elem_out,
	input logic              at_start,
	input logic              at_stop,
	input csb_pkg::seq_len_t seq_length,
	input csb_pkg::status_t  status
);

	// A stalled result keeps its contents until its transfer.
	`CSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(elem_out) && $stable(status) && $stable(seq_length), "result changed while stalled")

	// A cursor past the last byte reports a zero byte.
	`CSB_ASSERT_NOW(a_stop_zero, out_valid && at_stop, elem_out == '0, "non-zero byte at stop")

	// A refused insert only happens with the store at capacity.
	`CSB_ASSERT_NOW(a_full_len, out_valid && (status == csb_pkg::STAT_FULL), seq_length == csb_pkg::SEQ_LEN_W'(CAPACITY), "full status below capacity")

	// A command refused at stop leaves the cursor at stop.
	`CSB_ASSERT_NOW(a_refused_stop, out_valid && (status == csb_pkg::STAT_AT_STOP), at_stop, "stop refusal without cursor at stop")

endmodule

bind cursor_sequence_buffer_core csb_checker #(.CAPACITY(CAPACITY)) u_csb_checker (.*);

/* bench/cursor_sequence_buffer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core_test
// Self-checking bench for the cursor sequence buffer. A short table of
// commands covers the empty, single-byte and refused cases. The store is then
// filled to capacity and drained to eight bytes; random command streams follow.
// Every result is checked field by field against its table entry or a behavioural
// model of the sequence kept in the bench. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core_test;

	localparam int CAPACITY      = 256;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 120;
	localparam int RANDOM_PHASES = 4;
	localparam int CYCLE_LIMIT   = 2000000;

	// Codes 6 and 7 carry no operation.
	localparam csb_pkg::cmd_t CMD_SPARE6 = 3'd6;
	localparam csb_pkg::cmd_t CMD_SPARE7 = 3'd7;

	typedef struct packed {
		csb_pkg::elem_t    elem;
		logic              start;
		logic              stop;
		csb_pkg::seq_len_t len;
		csb_pkg::status_t  stat;
	} seq_result_t;

	typedef struct {
		csb_pkg::cmd_t  cmd;
		csb_pkg::elem_t value;
		bit             typed;
		seq_result_t    want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	csb_pkg::cmd_t     command;
	csb_pkg::elem_t    elem_in;
	logic              out_valid;
	logic              out_ready;
	csb_pkg::elem_t    elem_out;
	logic              at_start;
	logic              at_stop;
	csb_pkg::seq_len_t seq_length;
	csb_pkg::status_t  status;

	// Model of the sequence and its cursor.
	csb_pkg::elem_t seq_bytes [CAPACITY];
	int    cur_pos;
	int    seq_count;

	seq_result_t pending_results [$];
	stim_row_t   directed_rows [$];
	bit          row_typed;
	seq_result_t row_expect;
	bit          no_idle;
	bit          hold_request;
	int          error_count = 0;
	int          cycle_count = 0;

	cursor_sequence_buffer_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.elem_in   (elem_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.elem_out  (elem_out),
		.at_start  (at_start),
		.at_stop   (at_stop),
		.seq_length(seq_length),
		.status    (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit, counted in clock cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Opens a slot at the given position and writes the byte into it.
	function automatic void open_slot(input int at, input csb_pkg::elem_t value);
		for (int i = seq_count; i > at; i--)
			seq_bytes[i] = seq_bytes[i - 1];
		seq_bytes[at] = value;
		seq_count++;
	endfunction

	// Applies one command to the model and returns the result it reports.
	function automatic seq_result_t apply_command(input csb_pkg::cmd_t cmd,
			input csb_pkg::elem_t value);
		seq_result_t      r;
		csb_pkg::status_t st;
		bit               was_stop;
		st = csb_pkg::STAT_OK;
		was_stop = (cur_pos >= seq_count);
		case (cmd)
			csb_pkg::CMD_REWIND: cur_pos = 0;
			csb_pkg::CMD_STEP: begin
				if (was_stop)
					st = csb_pkg::STAT_AT_STOP;
				else
					cur_pos++;
			end
			csb_pkg::CMD_INS_L: begin
				if (seq_count >= CAPACITY)
					st = csb_pkg::STAT_FULL;
				else
					open_slot(cur_pos, value);
			end
			csb_pkg::CMD_INS_R: begin
				if (seq_count >= CAPACITY) begin
					st = csb_pkg::STAT_FULL;
				end else if (seq_count == 0) begin
					cur_pos = 0;
					open_slot(0, value);
				end else if (was_stop) begin
					st = csb_pkg::STAT_AT_STOP;
				end else begin
					cur_pos++;
					open_slot(cur_pos, value);
				end
			end
			csb_pkg::CMD_ERASE: begin
				if (was_stop) begin
					st = csb_pkg::STAT_AT_STOP;
				end else begin
					for (int i = cur_pos; i < seq_count - 1; i++)
						seq_bytes[i] = seq_bytes[i + 1];
					seq_count--;
				end
			end
			csb_pkg::CMD_READ: begin
				if (was_stop)
					st = csb_pkg::STAT_AT_STOP;
			end
			default: ;
		endcase
		r.stop  = (cur_pos >= seq_count);
		r.elem  = r.stop ? '0 : seq_bytes[cur_pos];
		r.start = (cur_pos == 0);
		r.len   = csb_pkg::seq_len_t'(seq_count);
		r.stat  = st;
		return r;
	endfunction

	function automatic seq_result_t res(input csb_pkg::elem_t e, input logic s0,
			input logic s1, input int len, input csb_pkg::status_t st);
		seq_result_t r;
		r.elem  = e;
		r.start = s0;
		r.stop  = s1;
		r.len   = csb_pkg::seq_len_t'(len);
		r.stat  = st;
		return r;
	endfunction

	function automatic void add_row(input csb_pkg::cmd_t cmd, input csb_pkg::elem_t value,
			input bit typed, input seq_result_t want);
		stim_row_t row;
		row.cmd   = cmd;
		row.value = value;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Offers one command and holds it until the transfer takes place.
	task automatic send_item(input csb_pkg::cmd_t cmd, input csb_pkg::elem_t value,
			input bit typed, input seq_result_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		repeat (gap) @(posedge clk);
		command    <= cmd;
		elem_in    <= value;
		in_valid   <= 1'b1;
		row_typed  = typed;
		row_expect = want;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Records the expectation of every command transfer and checks every result
	// transfer against the oldest one.
	always @(posedge clk) begin : result_check
		seq_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = apply_command(command, elem_in);
				if (row_typed)
					want = row_expect;
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: result with nothing expected, elem_out %0h status %0h",
						$time, elem_out, status);
				end else begin
					want = pending_results.pop_front();
					compare_field("elem_out", want.elem, elem_out);
					compare_field("at_start", want.start, at_start);
					compare_field("at_stop", want.stop, at_stop);
					compare_field("seq_length", want.len, seq_length);
					compare_field("status", want.stat, status);
				end
			end
		end
	end

	// Result side: random stalls, a run with none, and one long hold-off.
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_request) begin
				stall += LONG_HOLD;
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Command side: reset, directed table, fill and drain, then random phases.
	initial begin : command_source
		int            roll;
		csb_pkg::cmd_t pick;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		command      <= csb_pkg::CMD_REWIND;
		elem_in      <= '0;
		no_idle      = 1'b0;
		hold_request = 1'b0;
		row_typed    = 1'b0;
		row_expect   = '0;
		cur_pos      = 0;
		seq_count    = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Empty sequence, the first two bytes, and refusals at stop.
		add_row(csb_pkg::CMD_READ,   8'h00, 1'b1,
			res(8'h00, 1'b1, 1'b1, 0, csb_pkg::STAT_AT_STOP));
		add_row(csb_pkg::CMD_STEP,   8'hFF, 1'b1,
			res(8'h00, 1'b1, 1'b1, 0, csb_pkg::STAT_AT_STOP));
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b1,
			res(8'h00, 1'b1, 1'b1, 0, csb_pkg::STAT_AT_STOP));
		add_row(csb_pkg::CMD_INS_R,  8'hFF, 1'b1,
			res(8'hFF, 1'b1, 1'b0, 1, csb_pkg::STAT_OK));
		add_row(csb_pkg::CMD_INS_R,  8'h00, 1'b1,
			res(8'h00, 1'b0, 1'b0, 2, csb_pkg::STAT_OK));
		add_row(csb_pkg::CMD_STEP,   8'h00, 1'b1,
			res(8'h00, 1'b0, 1'b1, 2, csb_pkg::STAT_OK));
		add_row(csb_pkg::CMD_INS_R,  8'h3C, 1'b1,
			res(8'h00, 1'b0, 1'b1, 2, csb_pkg::STAT_AT_STOP));
		add_row(csb_pkg::CMD_INS_L,  8'hA5, 1'b0, '0);
		add_row(csb_pkg::CMD_REWIND, 8'h00, 1'b1,
			res(8'hFF, 1'b1, 1'b0, 3, csb_pkg::STAT_OK));
		add_row(csb_pkg::CMD_INS_L,  8'h5A, 1'b0, '0);
		add_row(csb_pkg::CMD_READ,   8'h00, 1'b0, '0);
		add_row(CMD_SPARE6,          8'hFF, 1'b0, '0);
		add_row(CMD_SPARE7,          8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_STEP,   8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_INS_R,  8'h81, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_STEP,   8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_REWIND, 8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_ERASE,  8'h00, 1'b0, '0);
		add_row(csb_pkg::CMD_READ,   8'h00, 1'b1,
			res(8'h00, 1'b1, 1'b1, 0, csb_pkg::STAT_AT_STOP));
		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].want);
		wait_drained();

		// Fill by appending, then the longest shift up to a full store.
		while (seq_count < CAPACITY - 1)
			send_item(csb_pkg::CMD_INS_R, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		send_item(csb_pkg::CMD_REWIND, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		send_item(csb_pkg::CMD_INS_L, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		send_item(csb_pkg::CMD_INS_R, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		send_item(csb_pkg::CMD_INS_L, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		send_item(csb_pkg::CMD_READ, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);

		// Drain from the front, each erase shifting the whole remainder.
		while (seq_count > 8)
			send_item(csb_pkg::CMD_ERASE, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
		wait_drained();

		// Random command streams; the sequence is kept short so shifts stay cheap.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			no_idle = (ph == 1);
			if (ph == 2)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (seq_count > 48 && roll < 60)
					pick = (cur_pos >= seq_count) ? csb_pkg::CMD_REWIND : csb_pkg::CMD_ERASE;
				else if (roll < 5)
					pick = csb_pkg::CMD_REWIND;
				else if (roll < 25)
					pick = csb_pkg::CMD_STEP;
				else if (roll < 45)
					pick = csb_pkg::CMD_INS_L;
				else if (roll < 62)
					pick = csb_pkg::CMD_INS_R;
				else if (roll < 82)
					pick = csb_pkg::CMD_ERASE;
				else if (roll < 95)
					pick = csb_pkg::CMD_READ;
				else
					pick = roll[0] ? CMD_SPARE6 : CMD_SPARE7;
				send_item(pick, csb_pkg::elem_t'($urandom_range(0, 255)), 1'b0, '0);
			end
			wait_drained();
		end

		// Allow for a stray late result before the verdict.
		repeat (CAPACITY + 20) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/csb_pkg.sv
hdl/csb_ram.sv
hdl/cursor_sequence_buffer_core.sv
hdl/csb_checker.sv
bench/cursor_sequence_buffer_core_test.sv
